FILE: rtl/deadline_job_greedy_max_heap_unit_defines.svh
// ----------------------------------------------------------------------------
// Deadline job scheduler: assertion macros
// Shared macros for the concurrent checks on the scheduler ports.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_JOB_GREEDY_MAX_HEAP_UNIT_DEFINES_SVH
`define DEADLINE_JOB_GREEDY_MAX_HEAP_UNIT_DEFINES_SVH

// clocked check, quiet while reset is asserted
`define DJGH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that is also evaluated during reset
`define DJGH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/djgh_pkg.sv
// ----------------------------------------------------------------------------
// Deadline job scheduler package
// Item types and the entry type carried along the sorted cell chains.
// ----------------------------------------------------------------------------
package djgh_pkg;

	localparam int unsigned DelayW = 16;
	localparam int unsigned RewardW = 16;
	localparam int unsigned TotalW = 26;
	localparam int unsigned DayW = 17;

	// input item
	typedef struct packed {
		logic [DelayW-1:0]  delay;
		logic [RewardW-1:0] reward;
		logic               last_job;
	} job_in_t;

	// result item
	typedef struct packed {
		logic [TotalW-1:0] total_reward;
		logic              overflow;
	} job_out_t;

	// one chain entry: sort key and attached data
	typedef struct packed {
		logic [15:0] key;
		logic [15:0] data;
	} entry_t;

	// operation broadcast to every cell of a chain
	typedef struct packed {
		logic   push;
		logic   pop;
		logic   clear;
		entry_t ent;
	} chain_op_t;

	localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

endpackage

FILE: rtl/djgh_cell.sv
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one entry; on push it keeps, takes the new entry or takes its left
// neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module djgh_cell #(
	parameter bit DESCEND = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  djgh_pkg::chain_op_t op,
	input  logic               prev_valid,
	input  logic               prev_stays,
	input  djgh_pkg::entry_t   prev_ent,
	input  logic               next_valid,
	input  djgh_pkg::entry_t   next_ent,
	output logic               valid,
	output logic               stays,
	output djgh_pkg::entry_t   ent
);
	import djgh_pkg::*;

	logic   valid_q;
	entry_t ent_q;

	// entry keeps its place when it orders ahead of or ties with the new one
	always_comb begin
		if (DESCEND) begin
			stays = valid_q && (ent_q.key >= op.ent.key);
		end else begin
			stays = valid_q && (ent_q.key <= op.ent.key);
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.clear) begin
			valid_q <= 1'b0;
		end else if (op.pop) begin
			valid_q <= next_valid;
		end else if (op.push && !stays) begin
			valid_q <= prev_stays ? 1'b1 : prev_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (op.pop) begin
			ent_q <= next_ent;
		end else if (op.push && !stays) begin
			ent_q <= prev_stays ? op.ent : prev_ent;
		end
	end

	assign valid = valid_q;
	assign ent   = ent_q;

endmodule

FILE: rtl/djgh_chain.sv
// ----------------------------------------------------------------------------
// Sorted cell chain
// A row of cells kept in key order; head is the first entry in order.
// ----------------------------------------------------------------------------
module djgh_chain #(
	parameter int unsigned DEPTH   = 1024,
	parameter bit          DESCEND = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  djgh_pkg::chain_op_t op,
	output logic                head_valid,
	output djgh_pkg::entry_t    head_ent,
	output logic                full
);
	import djgh_pkg::*;

	logic   cell_valid [DEPTH];
	logic   cell_stays [DEPTH];
	entry_t cell_ent   [DEPTH];

	// cell row with neighbor links
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   pv, ps, nv;
		entry_t pe, ne;
		if (i == 0) begin : g_first
			assign pv = 1'b0;
			assign ps = 1'b1;
			assign pe = '0;
		end else begin : g_mid
			assign pv = cell_valid[i-1];
			assign ps = cell_stays[i-1];
			assign pe = cell_ent[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign nv = 1'b0;
			assign ne = '0;
		end else begin : g_inner
			assign nv = cell_valid[i+1];
			assign ne = cell_ent[i+1];
		end
		djgh_cell #(.DESCEND(DESCEND)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.prev_valid (pv),
			.prev_stays (ps),
			.prev_ent   (pe),
			.next_valid (nv),
			.next_ent   (ne),
			.valid      (cell_valid[i]),
			.stays      (cell_stays[i]),
			.ent        (cell_ent[i])
		);
	end

	assign head_valid = cell_valid[0];
	assign head_ent   = cell_ent[0];
	assign full       = cell_valid[DEPTH-1];

endmodule

FILE: rtl/deadline_job_greedy_max_heap_unit.sv
// ----------------------------------------------------------------------------
// Deadline job scheduler
// Loads jobs into a delay-sorted cell chain, then walks the days, moving due
// jobs into a reward-sorted chain and taking its best entry each day.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in        in         in_valid/in_stall   job_in_t  (delay, reward, last_job)
//  out       out        out_valid/out_stall job_out_t (total_reward, overflow)
//  cfg       in         cfg_we             cfg_wdata (days)
//
// Loading accepts one item per cycle. After the last item, each schedule step
// drops or moves one job from the delay chain, takes one reward from the
// reward chain, or skips ahead to the next due day; a final step finishes.
// Reset clears control state and all chain valid bits; nothing is swept.
// Input is stalled from the last item until its result is taken.
// ----------------------------------------------------------------------------
module deadline_job_greedy_max_heap_unit #(
	parameter int unsigned MAX_JOBS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  djgh_pkg::job_in_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output djgh_pkg::job_out_t out_data,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);
	import djgh_pkg::*;

	localparam logic [1:0] StLoad = 2'd0;
	localparam logic [1:0] StRun  = 2'd1;
	localparam logic [1:0] StOut  = 2'd2;

	logic [1:0]        state_q;
	logic [15:0]       days_q;
	logic [DayW-1:0]   day_q;
	logic [TotalW-1:0] total_q;
	logic              ovf_q;
	job_out_t          out_q;

	chain_op_t a_op, b_op;
	logic      a_hv, b_hv, a_full, b_full;
	entry_t    a_he, b_he;

	logic            in_acc, finish, a_live;
	logic [TotalW:0] sum;

	// delay-sorted job table
	djgh_chain #(.DEPTH(MAX_JOBS), .DESCEND(1'b0)) u_jobs (
		.clk(clk), .arst_n(arst_n), .op(a_op),
		.head_valid(a_hv), .head_ent(a_he), .full(a_full)
	);

	// reward-sorted ready queue
	djgh_chain #(.DEPTH(MAX_JOBS), .DESCEND(1'b1)) u_ready (
		.clk(clk), .arst_n(arst_n), .op(b_op),
		.head_valid(b_hv), .head_ent(b_he), .full(b_full)
	);

	assign in_stall = (state_q != StLoad);
	assign in_acc   = in_valid && !in_stall;
	assign a_live   = a_hv && (a_he.key <= days_q);
	assign sum      = {1'b0, total_q} + (TotalW+1)'(b_he.key);

	// day step decisions
	always_comb begin
		a_op = '0;
		b_op = '0;
		finish = 1'b0;
		a_op.ent.key  = in_data.delay;
		a_op.ent.data = in_data.reward;
		b_op.ent.key  = a_he.data;
		if (state_q == StLoad) begin
			a_op.push = in_acc && !a_full;
		end else if (state_q == StRun) begin
			priority if (day_q > {1'b0, days_q}) begin
				finish = 1'b1;
			end else if (a_hv && a_he.key == '0) begin
				a_op.pop = 1'b1;
			end else if (a_live && {1'b0, a_he.key} == day_q) begin
				a_op.pop  = 1'b1;
				b_op.push = !b_full;
			end else if (b_hv) begin
				b_op.pop = 1'b1;
			end else if (!a_live) begin
				finish = 1'b1;
			end
		end
		a_op.clear = finish;
		b_op.clear = finish;
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_q <= '0;
		end else if (cfg_we) begin
			days_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
			day_q   <= '0;
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				StLoad: begin
					if (in_acc) begin
						if (a_full) ovf_q <= 1'b1;
						if (in_data.last_job) begin
							state_q <= StRun;
							day_q   <= DayW'(1);
							total_q <= '0;
						end
					end
				end
				StRun: begin
					if (finish) begin
						state_q <= StOut;
					end else if (!(a_hv && a_he.key == '0)
						&& !(a_live && {1'b0, a_he.key} == day_q)) begin
						if (b_hv) begin
							total_q <= sum[TotalW] ? TotalMax : sum[TotalW-1:0];
							day_q   <= day_q + DayW'(1);
						end else begin
							// nothing ready: skip ahead to the next due job
							day_q <= {1'b0, a_he.key};
						end
					end
				end
				StOut: begin
					if (!out_stall) begin
						state_q <= StLoad;
						ovf_q   <= 1'b0;
					end
				end
				default: state_q <= StLoad;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == StRun && finish) begin
			out_q.total_reward <= total_q;
			out_q.overflow     <= ovf_q;
		end
	end

	assign out_valid = (state_q == StOut);
	assign out_data  = out_q;

endmodule

FILE: rtl/djgh_checker.sv
// ----------------------------------------------------------------------------
// Deadline job scheduler port checker
// Watches the top-level ports for ordering of items and results.
// ----------------------------------------------------------------------------
`include "deadline_job_greedy_max_heap_unit_defines.svh"

module djgh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input djgh_pkg::job_in_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input djgh_pkg::job_out_t out_data
);
	import djgh_pkg::*;

	// a waiting result holds
	`DJGH_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")
	// one result per batch
	`DJGH_ASSERT(a_out_once, clk, arst_n, out_valid && !out_stall |=> !out_valid, "result repeated")
	// no item taken while a result waits
	`DJGH_ASSERT(a_no_in_out, clk, arst_n, out_valid |-> in_stall, "item accepted during result")
	// last item starts the schedule
	`DJGH_ASSERT(a_last_run, clk, arst_n, in_valid && !in_stall && in_data.last_job |=> in_stall, "input open after last item")

endmodule

bind deadline_job_greedy_max_heap_unit djgh_checker u_djgh_checker (.*);

FILE: bench/deadline_job_greedy_max_heap_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline job scheduler testbench
// Loads job batches with random gaps on both sides, predicts each batch total
// with a greedy day-by-day schedule or a typed expectation, and compares every
// result item in order.
module deadline_job_greedy_max_heap_unit_tb;
	import djgh_pkg::*;

	localparam int unsigned MaxJobs = 1024;
	localparam int unsigned CycleLimit = 4000000;
	localparam int unsigned MaxReport = 10;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	job_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	job_out_t out_data;
	logic     cfg_we;
	logic [15:0] cfg_wdata;

	// predictor state
	logic [15:0] days_reg;
	logic [15:0] batch_delay[$];
	logic [15:0] batch_reward[$];
	logic        batch_dropped;
	job_out_t    pending_totals[$];

	// typed expectation for the next last item
	bit          use_typed;
	job_out_t    typed_want;

	int unsigned mismatches;
	int unsigned cycles;
	int unsigned items_sent;

	// directed rows: delay, reward, last, days before row (-1 keeps), expected
	typedef struct {
		int          set_days;
		logic [15:0] delay;
		logic [15:0] reward;
		logic        last;
		bit          typed;
		job_out_t    want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	deadline_job_greedy_max_heap_unit #(.MAX_JOBS(MaxJobs)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// greedy schedule over the stored batch
	function automatic job_out_t greedy_total();
		job_out_t    res;
		logic [15:0] pool[$];
		logic [31:0] acc;
		int          best;
		int unsigned d;
		int          left;
		acc = 0;
		left = batch_delay.size();
		for (d = 1; d <= days_reg && (left > 0 || pool.size() > 0); d++) begin
			for (int k = 0; k < batch_delay.size(); k++) begin
				if (batch_delay[k] == d) begin
					pool.insert(pool.size(), batch_reward[k]);
					left--;
				end
			end
			if (pool.size() > 0) begin
				best = 0;
				foreach (pool[j]) if (pool[j] > pool[best]) best = j;
				acc += pool[best];
				if (acc > TotalMax) acc = TotalMax;
				pool.delete(best);
			end
		end
		res.total_reward = acc[TotalW-1:0];
		res.overflow = batch_dropped;
		return res;
	endfunction

	// note one accepted job in the predictor
	function automatic void record_job(job_in_t j);
		if (batch_delay.size() < MaxJobs) begin
			batch_delay.insert(batch_delay.size(), j.delay);
			batch_reward.insert(batch_reward.size(), j.reward);
		end else begin
			batch_dropped = 1'b1;
		end
		if (j.last_job) begin
			pending_totals.insert(pending_totals.size(),
				use_typed ? typed_want : greedy_total());
			use_typed = 1'b0;
			batch_delay.delete();
			batch_reward.delete();
			batch_dropped = 1'b0;
		end
	endfunction

	// random idle time; valid drops only when a gap follows
	task automatic idle_gap();
		int unsigned n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// present one job and wait until it is taken
	task automatic send_job(logic [15:0] dl, logic [15:0] rw, logic lst);
		job_in_t j;
		j.delay = dl;
		j.reward = rw;
		j.last_job = lst;
		in_data <= j;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		record_job(j);
		items_sent++;
		@(negedge clk);
		idle_gap();
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_totals.size() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_days(logic [15:0] v);
		wait_drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		days_reg = v;
	endtask

	function automatic void add_row(int sd, logic [15:0] dl, logic [15:0] rw, logic lst,
			bit typed = 0, logic [TotalW-1:0] tot = 0, logic ovf = 0);
		dir_row_t r;
		r.set_days = sd;
		r.delay = dl;
		r.reward = rw;
		r.last = lst;
		r.typed = typed;
		r.want.total_reward = tot;
		r.want.overflow = ovf;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// result checker
	always @(posedge clk) begin
		job_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_totals.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReport)
					$display("unexpected result total=%0d ovf=%0b",
						out_data.total_reward, out_data.overflow);
			end else begin
				want = pending_totals.pop_front();
				if (want.total_reward !== out_data.total_reward ||
						want.overflow !== out_data.overflow) begin
					mismatches++;
					if (mismatches <= MaxReport)
						$display("total exp=%0d got=%0d  ovf exp=%0b got=%0b",
							want.total_reward, out_data.total_reward,
							want.overflow, out_data.overflow);
				end
			end
		end
	end

	// receiver stall pattern
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
					: $urandom_range(1, 2)) @(negedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int unsigned blen;
		int unsigned dmax;
		logic [15:0] dl;
		mismatches = 0;
		items_sent = 0;
		use_typed = 1'b0;
		typed_want = '0;
		days_reg = 0;
		batch_dropped = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// days zero after reset gives nothing
		add_row(-1, 16'd1, 16'hFFFF, 1'b1, 1, 0, 0);
		// one max job on a single day
		add_row(1, 16'd1, 16'hFFFF, 1'b1, 1, 26'hFFFF, 0);
		// zero delay and delay beyond days are skipped
		add_row(3, 16'd0, 16'd500, 1'b0);
		add_row(-1, 16'd4, 16'd600, 1'b0);
		add_row(-1, 16'hFFFF, 16'd700, 1'b1, 1, 0, 0);
		// several jobs contend for few days
		add_row(3, 16'd1, 16'd10, 1'b0);
		add_row(-1, 16'd1, 16'd30, 1'b0);
		add_row(-1, 16'd2, 16'd20, 1'b0);
		add_row(-1, 16'd3, 16'd0, 1'b0);
		add_row(-1, 16'd3, 16'd5, 1'b1);
		// widest days register with extreme delays
		add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		add_row(-1, 16'h8000, 16'h5555, 1'b0);
		add_row(-1, 16'hAAAA, 16'hAAAA, 1'b0);
		add_row(-1, 16'h5555, 16'h0000, 1'b1);
		add_row(2, 16'd2, 16'd1, 1'b1);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_days >= 0) write_days(dir_rows[i].set_days[15:0]);
			if (dir_rows[i].typed) begin
				wait_drain();
				typed_want = dir_rows[i].want;
				use_typed = 1'b1;
				send_job(dir_rows[i].delay, dir_rows[i].reward, dir_rows[i].last);
			end else begin
				send_job(dir_rows[i].delay, dir_rows[i].reward, dir_rows[i].last);
			end
		end

		// table full: overflow, with the dropped job marked last
		write_days(16'd8);
		for (int k = 0; k < MaxJobs + 2; k++)
			send_job(16'($urandom_range(0, 9)), 16'($urandom), k == MaxJobs + 1);

		// random batches over several day settings
		while (items_sent < 1850) begin
			case ($urandom_range(0, 5))
				0: write_days(16'd0);
				1: write_days(16'hFFFF);
				2: write_days(16'($urandom));
				default: write_days(16'($urandom_range(1, 40)));
			endcase
			repeat ($urandom_range(1, 4)) begin
				blen = $urandom_range(1, 30);
				dmax = (days_reg == 0) ? 3 : days_reg + 2;
				if (dmax > 16'hFFFF) dmax = 16'hFFFF;
				for (int k = 0; k < blen; k++) begin
					dl = ($urandom_range(0, 9) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, dmax));
					send_job(dl, ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
						k == blen - 1);
				end
			end
		end
		wait_drain();
		repeat (2 * MaxJobs + 20) @(negedge clk);
		if (mismatches == 0 && pending_totals.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
